// File: src/power_button_sequencer_defines.svh
// Assertion macros shared by the power button sequencer RTL.
// No dependencies; include by bare file name in files that assert.
`ifndef POWER_BUTTON_SEQUENCER_DEFINES_SVH
`define POWER_BUTTON_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked implication check; disabled while reset is asserted.
`define PBS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition that must never be true at a clock edge.
`define PBS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PBS_ASSERT_CLK(lbl, prop, msg)
`define PBS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// File: src/pbs_pkg.sv
// Package for the power button sequencer: item and result types, target,
// operation and register index codes. No dependencies.
`timescale 1ns / 1ps

package pbs_pkg;

  localparam int unsigned CFG_BITS  = 16;
  localparam int unsigned ELAP_BITS = 16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PULSE    = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_SHUTDOWN = 2'd2,
    REG_FORCE    = 2'd3
  } reg_idx_e;

  // Command targets; other codes are unknown targets.
  localparam logic [2:0] TGT_HUMANOID = 3'd1;
  localparam logic [2:0] TGT_AI       = 3'd2;
  localparam logic [2:0] TGT_CONV_ONE = 3'd3;
  localparam logic [2:0] TGT_CONV_TWO = 3'd4;
  localparam logic [2:0] TGT_NAV      = 3'd5;

  // Command operations; the remaining code behaves as off for level targets.
  localparam logic [1:0] OP_OFF   = 2'd0;
  localparam logic [1:0] OP_ON    = 2'd1;
  localparam logic [1:0] OP_PULSE = 2'd2;

  // Action codes.
  localparam logic ACT_POLL    = 1'b0;
  localparam logic ACT_COMMAND = 1'b1;

  // Pulse channel indexes.
  localparam int unsigned CH_NAV      = 0;
  localparam int unsigned CH_HUMANOID = 1;
  localparam int unsigned CH_AI       = 2;

  typedef struct packed {
    logic                 action;
    logic [ELAP_BITS-1:0] elapsed_ms;
    logic                 power_button;
    logic                 nav_alive;
    logic [2:0]           command_target;
    logic [1:0]           command_op;
  } item_t;

  typedef struct packed {
    logic nav_switch;
    logic humanoid_on;
    logic ai_on;
    logic power_hold;
    logic button_lamp;
    logic conv_one_enable;
    logic conv_two_enable;
    logic shutdown_request;
    logic command_ok;
  } result_t;

endpackage

// File: src/pbs_core.sv
// Sequencer state, configuration registers and the single-pass update logic.
// Depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_core #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [pbs_pkg::CFG_BITS-1:0] cfg_data_i,
  input  logic                         go_i,
  input  pbs_pkg::item_t               item_i,
  output pbs_pkg::result_t             res_o
);

  localparam int unsigned CW = (TIME_BITS > pbs_pkg::CFG_BITS) ? TIME_BITS : pbs_pkg::CFG_BITS;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [pbs_pkg::CFG_BITS-1:0] pulse_ms_q, window_q, shut_hold_q, force_hold_q;

  logic                 held_q, held_d;
  logic                 notified_q, notified_d;
  logic                 forced_q, forced_d;
  logic [TIME_BITS-1:0] hold_time_q, hold_time_d;
  logic [TIME_BITS-1:0] pulse_left_q [3];
  logic [TIME_BITS-1:0] pulse_left_d [3];
  logic [2:0]           drive_q, drive_d;
  logic                 power_hold_q, power_hold_d;
  logic                 lamp_q, lamp_d;
  logic [1:0]           conv_q, conv_d;

  logic [CW-1:0]        plen_w;
  logic [TIME_BITS-1:0] plen;
  logic [CW:0]          hold_sum;

  // Pulse length after clamping to the range of the counters.
  always_comb begin
    plen_w = CW'(pulse_ms_q);
    if (plen_w == '0) begin
      plen_w = CW'(1);
    end
    if (plen_w > CW'(TMAX)) begin
      plen_w = CW'(TMAX);
    end
    plen = plen_w[TIME_BITS-1:0];
  end

  assign hold_sum = (CW + 1)'(hold_time_q) + (CW + 1)'(item_i.elapsed_ms);

  always_comb begin
    logic shut;
    logic ok;
    held_d       = held_q;
    notified_d   = notified_q;
    forced_d     = forced_q;
    hold_time_d  = hold_time_q;
    pulse_left_d = pulse_left_q;
    drive_d      = drive_q;
    power_hold_d = power_hold_q;
    lamp_d       = lamp_q;
    conv_d       = conv_q;
    shut         = 1'b0;
    ok           = 1'b1;

    if (item_i.action == pbs_pkg::ACT_POLL) begin
      for (int i = 0; i < 3; i++) begin
        if (pulse_left_q[i] != '0) begin
          if (CW'(item_i.elapsed_ms) >= CW'(pulse_left_q[i])) begin
            pulse_left_d[i] = '0;
            drive_d[i]      = 1'b0;
          end else begin
            pulse_left_d[i] = pulse_left_q[i] - TIME_BITS'(item_i.elapsed_ms);
          end
        end
      end

      if (item_i.power_button) begin
        if (!held_q) begin
          // A new press restarts the hold timer without adding this interval.
          held_d      = 1'b1;
          hold_time_d = '0;
          notified_d  = 1'b0;
          forced_d    = 1'b0;
        end else if (hold_sum > (CW + 1)'(TMAX)) begin
          hold_time_d = TMAX;
        end else begin
          hold_time_d = hold_sum[TIME_BITS-1:0];
        end

        if (!item_i.nav_alive && CW'(hold_time_d) < CW'(window_q) &&
            pulse_left_d[pbs_pkg::CH_NAV] == '0 && !notified_d) begin
          drive_d[pbs_pkg::CH_NAV]      = 1'b1;
          pulse_left_d[pbs_pkg::CH_NAV] = plen;
          notified_d                    = 1'b1;
        end
        if (item_i.nav_alive && CW'(hold_time_d) >= CW'(shut_hold_q) && !notified_d) begin
          notified_d = 1'b1;
          lamp_d     = 1'b0;
          shut       = 1'b1;
        end
        if (CW'(hold_time_d) >= CW'(force_hold_q) && !forced_d) begin
          forced_d                 = 1'b1;
          drive_d[pbs_pkg::CH_NAV] = 1'b1;
          power_hold_d             = 1'b0;
        end
      end else if (held_q) begin
        held_d = 1'b0;
        if (forced_q) begin
          drive_d[pbs_pkg::CH_NAV] = 1'b0;
        end
      end

      if (item_i.nav_alive) begin
        power_hold_d = 1'b1;
        lamp_d       = 1'b1;
      end else if (!held_d) begin
        power_hold_d = 1'b0;
        lamp_d       = 1'b0;
      end
    end else begin
      unique case (item_i.command_target)
        pbs_pkg::TGT_HUMANOID: begin
          if (item_i.command_op == pbs_pkg::OP_PULSE) begin
            drive_d[pbs_pkg::CH_HUMANOID]      = 1'b1;
            pulse_left_d[pbs_pkg::CH_HUMANOID] = plen;
          end else begin
            drive_d[pbs_pkg::CH_HUMANOID] = (item_i.command_op == pbs_pkg::OP_ON);
          end
        end
        pbs_pkg::TGT_AI: begin
          if (item_i.command_op == pbs_pkg::OP_PULSE) begin
            drive_d[pbs_pkg::CH_AI]      = 1'b1;
            pulse_left_d[pbs_pkg::CH_AI] = plen;
          end else begin
            drive_d[pbs_pkg::CH_AI] = (item_i.command_op == pbs_pkg::OP_ON);
          end
        end
        pbs_pkg::TGT_CONV_ONE: conv_d[0] = (item_i.command_op == pbs_pkg::OP_ON);
        pbs_pkg::TGT_CONV_TWO: conv_d[1] = (item_i.command_op == pbs_pkg::OP_ON);
        pbs_pkg::TGT_NAV: begin
          if (item_i.command_op == pbs_pkg::OP_PULSE) begin
            drive_d[pbs_pkg::CH_NAV]      = 1'b1;
            pulse_left_d[pbs_pkg::CH_NAV] = plen;
          end else if (item_i.command_op == pbs_pkg::OP_OFF) begin
            power_hold_d = 1'b0;
          end
        end
        default: ok = 1'b0;
      endcase
    end

    res_o.nav_switch       = drive_d[pbs_pkg::CH_NAV];
    res_o.humanoid_on      = drive_d[pbs_pkg::CH_HUMANOID];
    res_o.ai_on            = drive_d[pbs_pkg::CH_AI];
    res_o.power_hold       = power_hold_d;
    res_o.button_lamp      = lamp_d;
    res_o.conv_one_enable  = conv_d[0];
    res_o.conv_two_enable  = conv_d[1];
    res_o.shutdown_request = shut;
    res_o.command_ok       = ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ms_q   <= pbs_pkg::CFG_BITS'(500);
      window_q     <= pbs_pkg::CFG_BITS'(1000);
      shut_hold_q  <= pbs_pkg::CFG_BITS'(2000);
      force_hold_q <= pbs_pkg::CFG_BITS'(7000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbs_pkg::REG_PULSE:    pulse_ms_q   <= cfg_data_i;
        pbs_pkg::REG_WINDOW:   window_q     <= cfg_data_i;
        pbs_pkg::REG_SHUTDOWN: shut_hold_q  <= cfg_data_i;
        pbs_pkg::REG_FORCE:    force_hold_q <= cfg_data_i;
        default:               ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= 1'b0;
      notified_q   <= 1'b0;
      forced_q     <= 1'b0;
      hold_time_q  <= '0;
      pulse_left_q <= '{default: '0};
      drive_q      <= '0;
      power_hold_q <= 1'b0;
      lamp_q       <= 1'b0;
      conv_q       <= 2'b11;
    end else if (go_i) begin
      held_q       <= held_d;
      notified_q   <= notified_d;
      forced_q     <= forced_d;
      hold_time_q  <= hold_time_d;
      pulse_left_q <= pulse_left_d;
      drive_q      <= drive_d;
      power_hold_q <= power_hold_d;
      lamp_q       <= lamp_d;
      conv_q       <= conv_d;
    end
  end

endmodule

// File: src/power_button_sequencer.sv
// Path: an accepted transaction is held in the input register, and its
// result is loaded into the result register, which drives the output.
// Throughput: one transaction per cycle while out_stall_i is low; the input
// and result registers let a new transaction enter while a result waits downstream.
// Reset (rst_ni, asynchronous, active low) restores the configuration
// defaults, empties both registers, and sets the converter enables high.
`timescale 1ns / 1ps
`include "power_button_sequencer_defines.svh"

// Top level of the power button sequencer: input register, result register
// and handshake control around pbs_core. Depends on pbs_pkg and pbs_core.
module power_button_sequencer #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [pbs_pkg::CFG_BITS-1:0]  cfg_data_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [pbs_pkg::ELAP_BITS-1:0] elapsed_ms_i,
  input  logic                          power_button_i,
  input  logic                          nav_alive_i,
  input  logic [2:0]                    command_target_i,
  input  logic [1:0]                    command_op_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          nav_switch_o,
  output logic                          humanoid_on_o,
  output logic                          ai_on_o,
  output logic                          power_hold_o,
  output logic                          button_lamp_o,
  output logic                          conv_one_enable_o,
  output logic                          conv_two_enable_o,
  output logic                          shutdown_request_o,
  output logic                          command_ok_o
);

  // The input register holds one accepted transaction until the core can
  // process it. It processes (and commits the sequencer state) only when the
  // result register is empty or is being drained in the same cycle.
  logic             in_valid_q;
  pbs_pkg::item_t   item_q;
  logic             out_valid_q;
  pbs_pkg::result_t res_q;
  pbs_pkg::result_t res_d;
  logic             advance;
  logic             in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  // The input register may refill in the same cycle that it empties.
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // The payload needs no reset; it is only used while in_valid_q is set.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action         <= action_i;
      item_q.elapsed_ms     <= elapsed_ms_i;
      item_q.power_button   <= power_button_i;
      item_q.nav_alive      <= nav_alive_i;
      item_q.command_target <= command_target_i;
      item_q.command_op     <= command_op_i;
    end
  end

  // All hold rules, pulse counters and command decode live in the core. Its
  // result reflects the state after the transaction in the input register.
  pbs_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .go_i      (advance),
    .item_i    (item_q),
    .res_o     (res_d)
  );

  // Result register: loads on every processed transaction and empties once
  // the downstream side takes it without a new result arriving.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign nav_switch_o       = res_q.nav_switch;
  assign humanoid_on_o      = res_q.humanoid_on;
  assign ai_on_o            = res_q.ai_on;
  assign power_hold_o       = res_q.power_hold;
  assign button_lamp_o      = res_q.button_lamp;
  assign conv_one_enable_o  = res_q.conv_one_enable;
  assign conv_two_enable_o  = res_q.conv_two_enable;
  assign shutdown_request_o = res_q.shutdown_request;
  assign command_ok_o       = res_q.command_ok;

  // A shutdown request only comes from a poll, and polls always report ok.
  `PBS_ASSERT_NEVER(a_shut_implies_ok, out_valid_q && res_q.shutdown_request && !res_q.command_ok, "shutdown request on a result without command_ok")
  // The input side stalls only while a transaction waits in the input register.
  `PBS_ASSERT_NEVER(a_stall_only_when_full, in_stall_o && !in_valid_q, "input stalled with an empty input register")
  // A waiting transaction with a free result register reaches the output next cycle.
  `PBS_ASSERT_CLK(a_empty_pipe_moves, in_valid_q && !out_valid_q |=> out_valid_q, "transaction did not advance into a free result register")
  // A result is dropped only after the downstream side took it.
  `PBS_ASSERT_CLK(a_result_not_lost, $fell(out_valid_q) |-> $past(!out_stall_i), "result register emptied while stalled")

endmodule

// File: tb/tb_power_button_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for power_button_sequencer: directed and random
// polls and commands with a class-based scoreboard. Depends on pbs_pkg and the block.

module tb_power_button_sequencer;

  // Run limits and stimulus sizes.
  localparam int unsigned CYCLE_LIMIT       = 400000;
  localparam int unsigned ITEMS_PER_SETTING = 215;
  localparam int unsigned NUM_SETTINGS      = 6;
  localparam int unsigned TAIL_CYCLES       = 10;

  // Codes that the package leaves unnamed: the spare operation and the
  // targets that the block must reject.
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  localparam logic [2:0]  TGT_NONE     = 3'd0;
  localparam logic [2:0]  TGT_SPARE_LO = 3'd6;
  localparam logic [2:0]  TGT_SPARE_HI = 3'd7;
  localparam logic [15:0] TIME_MAX     = 16'hFFFF;

  // The scoreboard keeps its own copy of the sequencer state and registers.
  // Every accepted input transaction is run through predict_levels and the
  // resulting output levels wait in expected_levels for the matching result.
  class sequencer_scoreboard;
    logic [15:0]      cfg_val[4];
    bit               button_held;
    bit               press_notified;
    bit               force_latched;
    logic [15:0]      hold_time;
    logic [15:0]      pulse_left[3];
    bit               drive_on[3];
    bit               power_hold;
    bit               lamp_on;
    bit               conv_en[2];
    pbs_pkg::result_t expected_levels[$];
    int unsigned      checked;
    int unsigned      errors;

    function new();
      cfg_val[pbs_pkg::REG_PULSE]    = 16'd500;
      cfg_val[pbs_pkg::REG_WINDOW]   = 16'd1000;
      cfg_val[pbs_pkg::REG_SHUTDOWN] = 16'd2000;
      cfg_val[pbs_pkg::REG_FORCE]    = 16'd7000;
      button_held    = 1'b0;
      press_notified = 1'b0;
      force_latched  = 1'b0;
      hold_time      = '0;
      for (int i = 0; i < 3; i++) begin
        pulse_left[i] = '0;
        drive_on[i]   = 1'b0;
      end
      power_hold = 1'b0;
      lamp_on    = 1'b0;
      conv_en[0] = 1'b1;
      conv_en[1] = 1'b1;
      checked    = 0;
      errors     = 0;
    endfunction

    function void set_reg(pbs_pkg::reg_idx_e idx, logic [15:0] val);
      cfg_val[idx] = val;
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction

    function void start_pulse(int unsigned ch);
      drive_on[ch]   = 1'b1;
      pulse_left[ch] = (cfg_val[pbs_pkg::REG_PULSE] == 16'd0) ? 16'd1
                                                               : cfg_val[pbs_pkg::REG_PULSE];
    endfunction

    function pbs_pkg::result_t predict_levels(pbs_pkg::item_t it);
      pbs_pkg::result_t r;
      bit               shut;
      bit               ok;
      logic [16:0]      sum;
      int unsigned      ch;
      shut = 1'b0;
      ok   = 1'b1;
      if (it.action == pbs_pkg::ACT_POLL) begin
        // Pulses count down first; one that runs out drops its drive level.
        for (int i = 0; i < 3; i++) begin
          if (pulse_left[i] != 16'd0) begin
            if (it.elapsed_ms >= pulse_left[i]) begin
              pulse_left[i] = '0;
              drive_on[i]   = 1'b0;
            end else begin
              pulse_left[i] = pulse_left[i] - it.elapsed_ms;
            end
          end
        end
        if (it.power_button) begin
          if (!button_held) begin
            button_held    = 1'b1;
            hold_time      = '0;
            press_notified = 1'b0;
            force_latched  = 1'b0;
          end else begin
            sum       = {1'b0, hold_time} + {1'b0, it.elapsed_ms};
            hold_time = sum[16] ? TIME_MAX : sum[15:0];
          end
          if (!it.nav_alive && hold_time < cfg_val[pbs_pkg::REG_WINDOW] &&
              pulse_left[pbs_pkg::CH_NAV] == 16'd0 && !press_notified) begin
            start_pulse(pbs_pkg::CH_NAV);
            press_notified = 1'b1;
          end
          if (it.nav_alive && hold_time >= cfg_val[pbs_pkg::REG_SHUTDOWN] &&
              !press_notified) begin
            press_notified = 1'b1;
            lamp_on        = 1'b0;
            shut           = 1'b1;
          end
          if (hold_time >= cfg_val[pbs_pkg::REG_FORCE] && !force_latched) begin
            force_latched             = 1'b1;
            drive_on[pbs_pkg::CH_NAV] = 1'b1;
            power_hold                = 1'b0;
          end
        end else if (button_held) begin
          button_held = 1'b0;
          if (force_latched) drive_on[pbs_pkg::CH_NAV] = 1'b0;
        end
        if (it.nav_alive) begin
          power_hold = 1'b1;
          lamp_on    = 1'b1;
        end else if (!button_held) begin
          power_hold = 1'b0;
          lamp_on    = 1'b0;
        end
      end else begin
        case (it.command_target)
          pbs_pkg::TGT_HUMANOID, pbs_pkg::TGT_AI: begin
            ch = (it.command_target == pbs_pkg::TGT_HUMANOID) ? pbs_pkg::CH_HUMANOID
                                                              : pbs_pkg::CH_AI;
            if (it.command_op == pbs_pkg::OP_PULSE) start_pulse(ch);
            else drive_on[ch] = (it.command_op == pbs_pkg::OP_ON);
          end
          pbs_pkg::TGT_CONV_ONE: conv_en[0] = (it.command_op == pbs_pkg::OP_ON);
          pbs_pkg::TGT_CONV_TWO: conv_en[1] = (it.command_op == pbs_pkg::OP_ON);
          pbs_pkg::TGT_NAV: begin
            if (it.command_op == pbs_pkg::OP_PULSE) start_pulse(pbs_pkg::CH_NAV);
            else if (it.command_op == pbs_pkg::OP_OFF) power_hold = 1'b0;
          end
          default: ok = 1'b0;
        endcase
      end
      r.nav_switch       = drive_on[pbs_pkg::CH_NAV];
      r.humanoid_on      = drive_on[pbs_pkg::CH_HUMANOID];
      r.ai_on            = drive_on[pbs_pkg::CH_AI];
      r.power_hold       = power_hold;
      r.button_lamp      = lamp_on;
      r.conv_one_enable  = conv_en[0];
      r.conv_two_enable  = conv_en[1];
      r.shutdown_request = shut;
      r.command_ok       = ok;
      return r;
    endfunction

    function void note_transaction(pbs_pkg::item_t it);
      expected_levels.push_back(predict_levels(it));
    endfunction

    function void check_transaction(pbs_pkg::result_t got);
      pbs_pkg::result_t want;
      string            names[9] = '{"nav_switch", "humanoid_on", "ai_on", "power_hold",
                                     "button_lamp", "conv_one_enable", "conv_two_enable",
                                     "shutdown_request", "command_ok"};
      if (expected_levels.size() == 0) begin
        errors++;
        $display("%0t: result %b arrived with no transaction outstanding", $time, got);
        return;
      end
      want = expected_levels.pop_front();
      checked++;
      for (int i = 0; i < 9; i++) begin
        if (got[8-i] !== want[8-i]) begin
          errors++;
          $display("%0t: %s expected %b actual %b", $time, names[i], want[8-i], got[8-i]);
        end
      end
    endfunction
  endclass

  // Clock, reset and every block input start at a known value.
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [1:0]       cfg_idx_i   = '0;
  logic [15:0]      cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             out_stall_i = 1'b0;
  pbs_pkg::item_t   drv         = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             nav_switch_o;
  logic             humanoid_on_o;
  logic             ai_on_o;
  logic             power_hold_o;
  logic             button_lamp_o;
  logic             conv_one_enable_o;
  logic             conv_two_enable_o;
  logic             shutdown_request_o;
  logic             command_ok_o;
  pbs_pkg::result_t got_levels;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent    = 0;
  int unsigned cycles        = 0;

  sequencer_scoreboard sb = new();

  // The result fields are packed in the same order as result_t.
  assign got_levels = {nav_switch_o, humanoid_on_o, ai_on_o, power_hold_o, button_lamp_o,
                       conv_one_enable_o, conv_two_enable_o, shutdown_request_o,
                       command_ok_o};

  power_button_sequencer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (drv.action),
    .elapsed_ms_i       (drv.elapsed_ms),
    .power_button_i     (drv.power_button),
    .nav_alive_i        (drv.nav_alive),
    .command_target_i   (drv.command_target),
    .command_op_i       (drv.command_op),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .nav_switch_o       (nav_switch_o),
    .humanoid_on_o      (humanoid_on_o),
    .ai_on_o            (ai_on_o),
    .power_hold_o       (power_hold_o),
    .button_lamp_o      (button_lamp_o),
    .conv_one_enable_o  (conv_one_enable_o),
    .conv_two_enable_o  (conv_two_enable_o),
    .shutdown_request_o (shutdown_request_o),
    .command_ok_o       (command_ok_o)
  );

  always #5 clk_i = ~clk_i;

  // Both channels are sampled at the rising edge, where the values driven at
  // the previous falling edge are stable. An input transaction is noted
  // before any result of the same edge is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_transaction(drv);
      if (out_valid_o && !out_stall_i) sb.check_transaction(got_levels);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               sb.pending());
      $display("tb_power_button_sequencer: FAIL");
      $finish;
    end
  end

  // The receiver stalls at random on every cycle, at the current rate.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_idle_pct);
  end

  // Offers one transaction, after a random number of idle cycles, and
  // returns at the falling edge that follows its acceptance. Valid stays
  // high when the next call has no idle cycle.
  task automatic send_item(pbs_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    drv        = it;
    in_valid_i = 1'b1;
    items_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Every transaction yields exactly one result, so an empty scoreboard
  // means the block holds nothing in flight.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(pbs_pkg::reg_idx_e idx, logic [15:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Fields that the block ignores for a given action still get random
  // values, so that every input bit toggles.
  function automatic pbs_pkg::item_t make_poll(logic [15:0] elapsed, logic pressed,
                                               logic alive);
    pbs_pkg::item_t it;
    it.action         = pbs_pkg::ACT_POLL;
    it.elapsed_ms     = elapsed;
    it.power_button   = pressed;
    it.nav_alive      = alive;
    it.command_target = 3'($urandom_range(7));
    it.command_op     = 2'($urandom_range(3));
    return it;
  endfunction

  function automatic pbs_pkg::item_t make_cmd(logic [2:0] tgt, logic [1:0] op);
    pbs_pkg::item_t it;
    it.action         = pbs_pkg::ACT_COMMAND;
    it.elapsed_ms     = 16'($urandom);
    it.power_button   = 1'($urandom);
    it.nav_alive      = 1'($urandom);
    it.command_target = tgt;
    it.command_op     = op;
    return it;
  endfunction

  // Elapsed times are scaled to the current hold thresholds so that a press
  // of a few polls crosses the window, shutdown and force limits, with the
  // extremes and tiny steps mixed in.
  function automatic logic [15:0] pick_elapsed();
    int unsigned top;
    top = sb.cfg_val[pbs_pkg::REG_WINDOW];
    if (sb.cfg_val[pbs_pkg::REG_SHUTDOWN] > top) top = sb.cfg_val[pbs_pkg::REG_SHUTDOWN];
    if (sb.cfg_val[pbs_pkg::REG_FORCE] > top) top = sb.cfg_val[pbs_pkg::REG_FORCE];
    case ($urandom_range(9))
      0:       return '0;
      1:       return TIME_MAX;
      2, 3:    return 16'($urandom_range(15));
      default: return 16'($urandom_range(top / 3 + 1));
    endcase
  endfunction

  // Random traffic: mostly press episodes (optional release, a held button
  // over several polls with an occasional nav-alive flip or stray command,
  // then a release), plus loose commands and fully random polls.
  task automatic run_random(int unsigned count);
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    logic        alive;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_item(make_cmd(3'($urandom_range(7)), 2'($urandom_range(3))));
      end else if (pick < 30) begin
        send_item(make_poll(16'($urandom), 1'($urandom), 1'($urandom)));
      end else begin
        alive = 1'($urandom);
        len   = $urandom_range(1, 8);
        if ($urandom_range(1) == 1) send_item(make_poll(pick_elapsed(), 1'b0, alive));
        repeat (len) begin
          if ($urandom_range(9) == 0) alive = ~alive;
          if ($urandom_range(14) == 0)
            send_item(make_cmd(3'($urandom_range(7)), 2'($urandom_range(3))));
          send_item(make_poll(pick_elapsed(), 1'b1, alive));
        end
        send_item(make_poll(pick_elapsed(), 1'b0, alive));
      end
    end
  endtask

  // Register sets: all minimum, small random, all maximum, a maximal pulse
  // with short holds, fully random, and a moderate set.
  task automatic apply_setting(int unsigned k);
    logic [15:0] v[4];
    case (k)
      0: v = '{16'd1, 16'd1, 16'd1, 16'd1};
      1: v = '{16'($urandom_range(1, 300)), 16'($urandom_range(1, 500)),
               16'($urandom_range(1, 1500)), 16'($urandom_range(1, 3000))};
      2: v = '{TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX};
      3: v = '{TIME_MAX, 16'd100, 16'd300, 16'd800};
      4: v = '{16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))};
      default: v = '{16'd50, 16'd200, 16'd400, 16'd900};
    endcase
    write_reg(pbs_pkg::REG_PULSE, v[0]);
    write_reg(pbs_pkg::REG_WINDOW, v[1]);
    write_reg(pbs_pkg::REG_SHUTDOWN, v[2]);
    write_reg(pbs_pkg::REG_FORCE, v[3]);
  endtask

  initial begin
    int unsigned send_pct[3] = '{34, 78, 0};
    int unsigned recv_pct[3] = '{78, 34, 0};
    int unsigned setting;

    // Reset is held low at the start and released at a falling edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];

    // Directed part, on the reset register values. Each named target gets commands,
    // some with the spare operation, and each rejected target is sent once.
    send_item(make_poll(16'd0, 1'b0, 1'b0));
    send_item(make_cmd(pbs_pkg::TGT_HUMANOID, pbs_pkg::OP_ON));
    send_item(make_cmd(pbs_pkg::TGT_HUMANOID, pbs_pkg::OP_PULSE));
    // A level command during a pulse leaves the pulse counting.
    send_item(make_cmd(pbs_pkg::TGT_HUMANOID, pbs_pkg::OP_OFF));
    send_item(make_cmd(pbs_pkg::TGT_AI, OP_SPARE));
    send_item(make_cmd(pbs_pkg::TGT_AI, pbs_pkg::OP_PULSE));
    send_item(make_cmd(pbs_pkg::TGT_CONV_ONE, pbs_pkg::OP_OFF));
    send_item(make_cmd(pbs_pkg::TGT_CONV_TWO, OP_SPARE));
    send_item(make_cmd(pbs_pkg::TGT_CONV_ONE, pbs_pkg::OP_ON));
    send_item(make_cmd(pbs_pkg::TGT_CONV_TWO, pbs_pkg::OP_PULSE));
    send_item(make_cmd(pbs_pkg::TGT_CONV_TWO, pbs_pkg::OP_ON));
    send_item(make_cmd(pbs_pkg::TGT_NAV, pbs_pkg::OP_ON));
    send_item(make_cmd(pbs_pkg::TGT_NAV, OP_SPARE));
    send_item(make_cmd(pbs_pkg::TGT_NAV, pbs_pkg::OP_PULSE));
    send_item(make_cmd(pbs_pkg::TGT_NAV, pbs_pkg::OP_OFF));
    send_item(make_cmd(TGT_NONE, pbs_pkg::OP_ON));
    send_item(make_cmd(TGT_SPARE_LO, pbs_pkg::OP_PULSE));
    send_item(make_cmd(TGT_SPARE_HI, pbs_pkg::OP_OFF));
    // A new press while the nav pulse still runs: no second pulse yet.
    send_item(make_poll(16'd100, 1'b1, 1'b0));
    // The pulses expire, and the press within the window pulses the nav PC.
    send_item(make_poll(16'd600, 1'b1, 1'b0));
    // The hold time saturates: the force hold drives the nav switch; no shutdown request, as this press was notified.
    send_item(make_poll(TIME_MAX, 1'b1, 1'b1));
    // Release after the force hold drops the nav switch.
    send_item(make_poll(16'd1, 1'b0, 1'b1));
    send_item(make_poll(TIME_MAX, 1'b0, 1'b0));

    // Three idle patterns, two register sets each. Registers change only
    // once every outstanding result has come back.
    setting = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = send_pct[phase];
      recv_idle_pct = recv_pct[phase];
      for (int seg = 0; seg < 2; seg++) begin
        wait_idle();
        apply_setting(setting);
        setting++;
        run_random(ITEMS_PER_SETTING / 2);
        // The sender holds off until the block has drained completely.
        if (seg == 0) wait_idle();
        run_random(ITEMS_PER_SETTING - ITEMS_PER_SETTING / 2);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end

    $display("Sent %0d transactions (polls, commands, press episodes) over %0d register sets",
             items_sent, NUM_SETTINGS);
    $display("and three idle patterns; %0d results checked, %0d errors.", sb.checked,
             sb.errors);
    if (sb.errors == 0) begin
      $display("tb_power_button_sequencer: PASS");
    end else begin
      $display("tb_power_button_sequencer: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/pbs_pkg.sv
src/pbs_core.sv
src/power_button_sequencer.sv
tb/tb_power_button_sequencer.sv
